/* hw/rtl/cascaded_reload_timer_bank_unit_defines.svh */
// ----------------------------------------------------------------------------
// cascaded_reload_timer_bank_unit_defines.svh
// Assertion macros for the cascaded reload timer bank.
// ----------------------------------------------------------------------------
`ifndef CASCADED_RELOAD_TIMER_BANK_UNIT_DEFINES_SVH
`define CASCADED_RELOAD_TIMER_BANK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CRTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CRTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/crtb_pkg.sv */
// ----------------------------------------------------------------------------
// crtb_pkg
// Types, constants and helpers shared by the timer bank modules.
// ----------------------------------------------------------------------------
package crtb_pkg;

  localparam int TIMER_COUNT = 4;
  localparam int TIMER_W     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CYCLES_W    = 12;
  localparam int DATA_W      = 16;
  localparam int CTL_W       = 8;
  localparam int ACC_W       = 10;
  localparam int IRQ_W       = 4;

  localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;

  // control byte bit positions
  localparam int CTL_CASCADE_BIT = 2;
  localparam int CTL_IRQ_BIT     = 6;
  localparam int CTL_ENABLE_BIT  = 7;

  // commands
  localparam logic [1:0] CMD_ELAPSE       = 2'd0;
  localparam logic [1:0] CMD_WRITE_RELOAD = 2'd1;
  localparam logic [1:0] CMD_WRITE_CTL    = 2'd2;
  localparam logic [1:0] CMD_READ_COUNT   = 2'd3;

  // prescale select codes
  localparam logic [1:0] PRE_DIV1    = 2'd0;
  localparam logic [1:0] PRE_DIV64   = 2'd1;
  localparam logic [1:0] PRE_DIV256  = 2'd2;
  localparam logic [1:0] PRE_DIV1024 = 2'd3;

  typedef struct packed {
    logic [1:0]          command;
    logic [1:0]          timer_index;
    logic [DATA_W-1:0]   write_data;
    logic [CYCLES_W-1:0] cycles;
  } crtb_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_mask;
  } crtb_rsp_t;

  // one timer's state as seen by the step unit
  typedef struct packed {
    logic [CTL_W-1:0]  ctl;
    logic [ACC_W-1:0]  acc;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] reload;
  } crtb_lane_t;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [DATA_W-1:0] count;
    logic              overflow;
  } crtb_step_t;

  function automatic logic [ACC_W:0] prescale_period(input logic [1:0] sel);
    logic [ACC_W:0] p;
    unique case (sel)
      PRE_DIV1:    p = (ACC_W+1)'(1);
      PRE_DIV64:   p = (ACC_W+1)'(64);
      PRE_DIV256:  p = (ACC_W+1)'(256);
      PRE_DIV1024: p = (ACC_W+1)'(1024);
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/crtb_step.sv */
// ----------------------------------------------------------------------------
// crtb_step
// Shared single-timer step: prescale, count, reload and cascade carry.
// ----------------------------------------------------------------------------
module crtb_step (
  input  crtb_pkg::crtb_lane_t lane,
  input  logic                 carry_in,
  output crtb_pkg::crtb_step_t result
);
  import crtb_pkg::*;

  logic           enabled;
  logic           cascade;
  logic           own_clock;
  logic [ACC_W:0] acc_sum;
  logic [ACC_W:0] period;
  logic           tick;
  logic           inc;
  logic           wrap;

  always_comb begin
    enabled   = lane.ctl[CTL_ENABLE_BIT];
    cascade   = lane.ctl[CTL_CASCADE_BIT];
    own_clock = enabled && !cascade;
    acc_sum   = {1'b0, lane.acc} + (ACC_W+1)'(1);
    period    = prescale_period(lane.ctl[1:0]);
    tick      = (acc_sum >= period);
    // cascade timers only move on the carry of the timer below
    inc       = own_clock ? tick : (enabled && cascade && carry_in);
    wrap      = inc && (lane.count == COUNT_MAX);

    if (own_clock) begin
      result.acc = tick ? ACC_W'(acc_sum - period) : ACC_W'(acc_sum);
    end else begin
      result.acc = lane.acc;
    end

    if (wrap) begin
      result.count = lane.reload;
    end else if (inc) begin
      result.count = lane.count + DATA_W'(1);
    end else begin
      result.count = lane.count;
    end
    result.overflow = wrap;
  end

endmodule

/* hw/rtl/cascaded_reload_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// cascaded_reload_timer_bank_unit
// Bank of 16-bit reload timers with prescaler and cascade, stepped per request.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one request: advance the bank by req.cycles
//   clock cycles, then apply a command to one timer (elapse, write reload,
//   write control, read counter). rsp (valid/ready) returns one response per
//   request: the counter value for a read (else zero) and the mask of timers
//   that overflowed with IRQ enabled during the request.
//   Timing: one shared step unit visits one timer per clock, so a request
//   advances every timer in turn for each of its cycles in S_RUN, then
//   applies its command in S_CMD, which posts rsp_valid; req_ready rises
//   in the same clock. A new request is taken only once the previous one
//   has posted its response; the bank does not overlap requests.
//   A finished response sits in the output register; the next request is
//   taken while it waits, and the command step holds until the slot frees.
//   Reset (rst, synchronous) clears all counters, reloads, control bytes and
//   prescale accumulators; every timer starts disabled.
// ----------------------------------------------------------------------------
`include "cascaded_reload_timer_bank_unit_defines.svh"

module cascaded_reload_timer_bank_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  crtb_pkg::crtb_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output crtb_pkg::crtb_rsp_t rsp
);
  import crtb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_CMD  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  localparam logic [TIMER_W-1:0] LAST = TIMER_W'(TIMER_COUNT - 1);

  logic [1:0]          state;
  logic [TIMER_W-1:0]  ptr;
  logic [CYCLES_W-1:0] remaining;
  logic                carry;
  logic [IRQ_W-1:0]    irq_acc;
  crtb_req_t           cur;

  logic [DATA_W-1:0] counter [TIMER_COUNT];
  logic [DATA_W-1:0] reload  [TIMER_COUNT];
  logic [CTL_W-1:0]  ctl     [TIMER_COUNT];
  logic [ACC_W-1:0]  acc     [TIMER_COUNT];

  logic [TIMER_W-1:0] sel;
  logic               in_range;
  logic               slot_free;
  logic               carry_in;
  logic [IRQ_W-1:0]   irq_hit;
  crtb_lane_t         lane;
  crtb_step_t         step;

  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;
  assign in_range  = (32'(cur.timer_index) < TIMER_COUNT);
  assign sel       = (state == S_CMD) ? TIMER_W'(cur.timer_index) : ptr;
  assign carry_in  = (ptr == '0) ? 1'b0 : carry;

  always_comb begin
    lane.ctl    = ctl[sel];
    lane.acc    = acc[sel];
    lane.count  = counter[sel];
    lane.reload = reload[sel];
  end

  crtb_step u_step (
    .lane     (lane),
    .carry_in (carry_in),
    .result   (step)
  );

  // timers past the mask width report nothing
  always_comb begin
    for (int b = 0; b < IRQ_W; b++) begin
      irq_hit[b] = (32'(ptr) == b) && step.overflow && lane.ctl[CTL_IRQ_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      remaining <= '0;
      carry     <= 1'b0;
      irq_acc   <= '0;
      rsp_valid <= 1'b0;
      for (int t = 0; t < TIMER_COUNT; t++) begin
        counter[t] <= '0;
        reload[t]  <= '0;
        ctl[t]     <= '0;
        acc[t]     <= '0;
      end
    end else begin
      // the command step reposts rsp_valid itself when it fires
      if (rsp_valid && rsp_ready && (state != S_CMD)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur       <= req;
            ptr       <= '0;
            carry     <= 1'b0;
            irq_acc   <= '0;
            remaining <= req.cycles;
            state     <= (req.cycles == '0) ? S_CMD : S_RUN;
          end
        end
        S_RUN: begin
          acc[ptr]     <= step.acc;
          counter[ptr] <= step.count;
          carry        <= step.overflow;
          irq_acc      <= irq_acc | irq_hit;
          if (ptr == LAST) begin
            ptr       <= '0;
            remaining <= remaining - CYCLES_W'(1);
            if (remaining == CYCLES_W'(1)) begin
              state <= S_CMD;
            end
          end else begin
            ptr <= ptr + TIMER_W'(1);
          end
        end
        S_CMD: begin
          if (slot_free) begin
            rsp.irq_mask  <= irq_acc;
            rsp.read_data <= '0;
            if (in_range) begin
              unique case (cur.command)
                CMD_ELAPSE: begin
                end
                CMD_WRITE_RELOAD: begin
                  reload[sel] <= cur.write_data;
                end
                CMD_WRITE_CTL: begin
                  ctl[sel] <= cur.write_data[CTL_W-1:0];
                  // rising enable loads the counter
                  if (!lane.ctl[CTL_ENABLE_BIT] && cur.write_data[CTL_ENABLE_BIT]) begin
                    counter[sel] <= lane.reload;
                  end
                end
                CMD_READ_COUNT: begin
                  rsp.read_data <= lane.count;
                end
              endcase
            end
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_HOLD: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CRTB_ASSERT_NEXT(a_zero_cycles_to_cmd, req_valid && req_ready && (req.cycles == '0), state == S_CMD, "zero-cycle request did not go to command step")
  `CRTB_ASSERT_NEXT(a_run_ends, (state == S_RUN) && (ptr == LAST) && (remaining == CYCLES_W'(1)), state == S_CMD, "advance did not end after last cycle")
  `CRTB_ASSERT_NEXT(a_cmd_delivers, (state == S_CMD) && slot_free, rsp_valid && (state == S_IDLE), "command step did not post a response")
  `CRTB_ASSERT_SAME(a_ptr_in_bank, state == S_RUN, 32'(ptr) < TIMER_COUNT, "timer pointer outside the bank")

endmodule
